[hw/rtl/zpb_pkg.sv]
// Shared types and constants for the z-buffered point binner.
package zpb_pkg;

    localparam int COORD_W     = 16;
    localparam int POINT_W     = 3 * COORD_W;
    localparam int DEPTH_W     = 17;
    localparam int WORD_W      = POINT_W + DEPTH_W;
    localparam int CLIP_W      = 34;
    localparam int DEPTH_NUM_W = 48;
    localparam int IDX_W       = 19;
    localparam int FUNC_W      = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_EMPTY = {DEPTH_W{1'b1}};

    localparam logic [FUNC_W-1:0] FUNC_BIN   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    typedef enum logic [1:0] {
        DIV_U,
        DIV_V,
        DIV_Z
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_NORM,
        ST_SCALE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ADDR,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_RD_RD,
        ST_RD_OUT
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       clr_init;
        logic       clr_step;
        logic       mac_en;
        logic [3:0] mac_step;
        logic       norm;
        logic       scale;
        logic       div_start;
        div_sel_t   div_sel;
        logic       addr;
        logic       bin_rd;
        logic       bin_wr;
        logic       rd_rd;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic div_done;
        logic on_screen;
        logic out_free;
    } stat_t;

endpackage

[hw/rtl/zpb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module zpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/zpb_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module zpb_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 34
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] nq_reg, nq_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh   = {rem_reg, nq_reg[NUM_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
        nq_next  = {nq_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            nq_reg  <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

[hw/rtl/zpb_ctrl.sv]
// Controller state machine that sequences clear, bin and read items.
module zpb_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [zpb_pkg::FUNC_W-1:0]   in_func,
    output logic                         in_ready,
    input  zpb_pkg::stat_t               stat,
    output zpb_pkg::cmd_t                cmd
);

    zpb_pkg::state_t   state_reg, state_next;
    logic [3:0]        step_reg, step_next;
    zpb_pkg::div_sel_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zpb_pkg::ST_CLEAR;
            step_reg  <= '0;
            phase_reg <= zpb_pkg::DIV_U;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        case (state_reg)
            zpb_pkg::ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = zpb_pkg::ST_IDLE;
                end
            end
            zpb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    step_next = '0;
                    case (in_func)
                        zpb_pkg::FUNC_BIN:   state_next = zpb_pkg::ST_MAC;
                        zpb_pkg::FUNC_CLEAR: state_next = zpb_pkg::ST_CLEAR;
                        zpb_pkg::FUNC_READ:  state_next = zpb_pkg::ST_RD_RD;
                        default:             state_next = zpb_pkg::ST_IDLE;
                    endcase
                end
            end
            zpb_pkg::ST_MAC:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'hF)
                begin
                    state_next = zpb_pkg::ST_NORM;
                end
            end
            zpb_pkg::ST_NORM:
            begin
                state_next = zpb_pkg::ST_SCALE;
            end
            zpb_pkg::ST_SCALE:
            begin
                phase_next = zpb_pkg::DIV_U;
                state_next = stat.bad ? zpb_pkg::ST_IDLE : zpb_pkg::ST_DIV_START;
            end
            zpb_pkg::ST_DIV_START:
            begin
                state_next = zpb_pkg::ST_DIV_WAIT;
            end
            zpb_pkg::ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    case (phase_reg)
                        zpb_pkg::DIV_U:
                        begin
                            phase_next = zpb_pkg::DIV_V;
                            state_next = zpb_pkg::ST_DIV_START;
                        end
                        zpb_pkg::DIV_V:
                        begin
                            phase_next = zpb_pkg::DIV_Z;
                            state_next = zpb_pkg::ST_DIV_START;
                        end
                        default:
                        begin
                            state_next = zpb_pkg::ST_ADDR;
                        end
                    endcase
                end
            end
            zpb_pkg::ST_ADDR:
            begin
                state_next = stat.on_screen ? zpb_pkg::ST_BIN_RD : zpb_pkg::ST_IDLE;
            end
            zpb_pkg::ST_BIN_RD:
            begin
                state_next = zpb_pkg::ST_BIN_WR;
            end
            zpb_pkg::ST_BIN_WR:
            begin
                state_next = zpb_pkg::ST_IDLE;
            end
            zpb_pkg::ST_RD_RD:
            begin
                state_next = zpb_pkg::ST_RD_OUT;
            end
            zpb_pkg::ST_RD_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = zpb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = zpb_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd          = '0;
        cmd.mac_step = step_reg;
        cmd.div_sel  = phase_reg;
        in_ready     = 1'b0;
        case (state_reg)
            zpb_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            zpb_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.accept   = in_valid;
                cmd.clr_init = in_valid && (in_func == zpb_pkg::FUNC_CLEAR);
            end
            zpb_pkg::ST_MAC:       cmd.mac_en    = 1'b1;
            zpb_pkg::ST_NORM:      cmd.norm      = 1'b1;
            zpb_pkg::ST_SCALE:     cmd.scale     = 1'b1;
            zpb_pkg::ST_DIV_START: cmd.div_start = 1'b1;
            zpb_pkg::ST_ADDR:      cmd.addr      = 1'b1;
            zpb_pkg::ST_BIN_RD:    cmd.bin_rd    = 1'b1;
            zpb_pkg::ST_BIN_WR:    cmd.bin_wr    = 1'b1;
            zpb_pkg::ST_RD_RD:     cmd.rd_rd     = 1'b1;
            zpb_pkg::ST_RD_OUT:    cmd.out_load  = stat.out_free;
            default:
            begin
                cmd.accept = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/zpb_dp.sv]
// Datapath: matrix multiply-accumulate, divider, pixel mapping and frame store.
module zpb_dp #(
    parameter int IMG_WIDTH  = 640,
    parameter int IMG_HEIGHT = 480
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  zpb_pkg::cmd_t                      cmd,
    output zpb_pkg::stat_t                     stat,
    input  logic [255:0]                       matrix,
    input  logic signed [zpb_pkg::COORD_W-1:0] pos_x,
    input  logic signed [zpb_pkg::COORD_W-1:0] pos_y,
    input  logic signed [zpb_pkg::COORD_W-1:0] pos_z,
    input  logic [zpb_pkg::IDX_W-1:0]          pixel_index,
    output logic [zpb_pkg::POINT_W-1:0]        out_point,
    output logic                               out_filled,
    output logic                               out_valid,
    input  logic                               out_ready
);

    localparam int NPIX   = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W = $clog2(NPIX);
    localparam int DIM_W  = $clog2(((IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT) + 1);
    localparam int CLIP_W = zpb_pkg::CLIP_W;
    localparam int SUM_W  = CLIP_W + 1;
    localparam int SC_W   = SUM_W + DIM_W + 1;
    localparam int NUM_W  = (SC_W > zpb_pkg::DEPTH_NUM_W) ? SC_W : zpb_pkg::DEPTH_NUM_W;
    localparam int DEN_W  = CLIP_W;
    localparam int DW     = zpb_pkg::DEPTH_W;

    // Latched item.
    logic signed [zpb_pkg::COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [zpb_pkg::IDX_W-1:0]          idx_reg;
    logic                               oob_reg;

    // Multiply-accumulate.
    logic [1:0]                  row, col;
    logic signed [15:0]          coef, opnd;
    logic signed [31:0]          prod;
    logic signed [CLIP_W-1:0]    acc_reg, acc_next;
    logic signed [CLIP_W-1:0]    clip_reg [4];
    logic signed [CLIP_W-1:0]    cx_reg, cy_reg, cz_reg, cw_reg;

    // Scale and divide.
    logic signed [SUM_W-1:0]     sum_x, sum_y;
    logic signed [SC_W-1:0]      su_reg, sv_reg, mag_u, mag_v;
    logic signed [SC_W-1:0]      w_sc, h_sc;
    logic [NUM_W-1:0]            div_num, div_quo;
    logic [DEN_W-1:0]            div_den;
    logic                        div_done;
    logic [NUM_W-1:0]            qu_reg, qv_reg;
    logic                        u_neg_reg, v_neg_reg;
    logic [DW-1:0]               depth_reg;

    // Pixel mapping.
    logic                        u_ok, v_ok;
    logic [DIM_W-1:0]            u_val, tv_val, v_val;
    logic [ADDR_W-1:0]           pix_reg;

    // Frame store.
    logic [ADDR_W-1:0]           clr_cnt_reg;
    logic                        we, re;
    logic [ADDR_W-1:0]           waddr, raddr;
    logic [zpb_pkg::WORD_W-1:0]  wdata, rdata;
    logic                        better;
    logic                        out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
            idx_reg <= pixel_index;
            oob_reg <= {13'd0, pixel_index} >= 32'(NPIX);
        end
    end

    assign row  = cmd.mac_step[3:2];
    assign col  = cmd.mac_step[1:0];
    assign coef = $signed(matrix[{row, col, 4'b0000} +: 16]);

    always_comb
    begin
        case (col)
            2'd0:    opnd = px_reg;
            2'd1:    opnd = py_reg;
            2'd2:    opnd = pz_reg;
            default: opnd = 16'sd256;
        endcase
        prod     = coef * opnd;
        acc_next = ((col == 2'd0) ? CLIP_W'(0) : acc_reg) + CLIP_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_en)
        begin
            acc_reg <= acc_next;
            if (col == 2'd3)
            begin
                clip_reg[row] <= acc_next;
            end
        end
        if (cmd.norm)
        begin
            if (clip_reg[3] < 0)
            begin
                cx_reg <= -clip_reg[0];
                cy_reg <= -clip_reg[1];
                cz_reg <= -clip_reg[2];
                cw_reg <= -clip_reg[3];
            end
            else
            begin
                cx_reg <= clip_reg[0];
                cy_reg <= clip_reg[1];
                cz_reg <= clip_reg[2];
                cw_reg <= clip_reg[3];
            end
        end
    end

    always_comb
    begin
        sum_x = SUM_W'(cx_reg) + SUM_W'(cw_reg);
        sum_y = SUM_W'(cy_reg) + SUM_W'(cw_reg);
        w_sc  = SC_W'($signed({1'b0, DIM_W'(IMG_WIDTH)}));
        h_sc  = SC_W'($signed({1'b0, DIM_W'(IMG_HEIGHT)}));
        mag_u = su_reg[SC_W-1] ? -su_reg : su_reg;
        mag_v = sv_reg[SC_W-1] ? -sv_reg : sv_reg;
        case (cmd.div_sel)
            zpb_pkg::DIV_U:
            begin
                div_num = NUM_W'($unsigned(mag_u));
                div_den = DEN_W'({cw_reg, 1'b0});
            end
            zpb_pkg::DIV_V:
            begin
                div_num = NUM_W'($unsigned(mag_v));
                div_den = DEN_W'({cw_reg, 1'b0});
            end
            default:
            begin
                div_num = NUM_W'({cz_reg, 16'h0000});
                div_den = DEN_W'(cw_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            su_reg <= SC_W'(sum_x) * w_sc;
            sv_reg <= SC_W'(sum_y) * h_sc;
        end
        if (div_done)
        begin
            case (cmd.div_sel)
                zpb_pkg::DIV_U:
                begin
                    qu_reg    <= div_quo;
                    u_neg_reg <= su_reg[SC_W-1];
                end
                zpb_pkg::DIV_V:
                begin
                    qv_reg    <= div_quo;
                    v_neg_reg <= sv_reg[SC_W-1];
                end
                default:
                begin
                    depth_reg <= div_quo[DW-1:0];
                end
            endcase
        end
    end

    zpb_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // A negative numerator is on screen only when it truncates to zero.
    always_comb
    begin
        u_ok   = (qu_reg == '0) || (!u_neg_reg && (qu_reg < NUM_W'(IMG_WIDTH)));
        v_ok   = (qv_reg == '0) || (!v_neg_reg && (qv_reg < NUM_W'(IMG_HEIGHT)));
        u_val  = u_neg_reg ? DIM_W'(0) : qu_reg[DIM_W-1:0];
        tv_val = v_neg_reg ? DIM_W'(0) : qv_reg[DIM_W-1:0];
        v_val  = DIM_W'(IMG_HEIGHT - 1) - tv_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.addr)
        begin
            pix_reg <= ADDR_W'(32'(v_val) * 32'(IMG_WIDTH) + 32'(u_val));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_init)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        better = depth_reg < rdata[DW-1:0];
        we     = cmd.clr_step || (cmd.bin_wr && better);
        waddr  = cmd.clr_step ? clr_cnt_reg : pix_reg;
        wdata  = cmd.clr_step ? {{zpb_pkg::POINT_W{1'b0}}, zpb_pkg::DEPTH_EMPTY}
                              : {pz_reg, py_reg, px_reg, depth_reg};
        re     = cmd.bin_rd || cmd.rd_rd;
        raddr  = cmd.rd_rd ? ADDR_W'(idx_reg) : pix_reg;
    end

    zpb_ram #(
        .WIDTH (zpb_pkg::WORD_W),
        .DEPTH (NPIX)
    ) u_frame (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_point  <= oob_reg ? '0 : rdata[zpb_pkg::WORD_W-1:DW];
            out_filled <= !oob_reg && (rdata[DW-1:0] != zpb_pkg::DEPTH_EMPTY);
        end
    end

    assign out_valid      = out_valid_reg;
    assign stat.clr_last  = clr_cnt_reg == ADDR_W'(NPIX - 1);
    assign stat.bad       = (cw_reg == '0) || (cz_reg < 0) || (cz_reg > cw_reg);
    assign stat.div_done  = div_done;
    assign stat.on_screen = u_ok && v_ok;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

[hw/rtl/zbuffer_point_binner_unit.sv]
// Top level of the z-buffered point binner: stream ports, matrix registers, core.

// The block projects 3D points through a 4x4 clip matrix held in four 64-bit
// registers and keeps, per pixel, the nearest point in a frame store of
// IMG_WIDTH*IMG_HEIGHT words. Items arrive on the slave stream with the
// function code in tuser. In a bin transaction a single multiply-accumulate
// unit forms the clip coordinates one coefficient at a time, and then the
// one-bit-per-cycle divider (48 bits wide at the default image size) is
// run three times for u, v and depth. A point with zero w or depth outside
// [0,1] is dropped early, before the divider runs. A read transaction waits
// for the output register to empty; it returns exactly one result. A clear
// transaction, and the period right after reset, sweeps all
// IMG_WIDTH*IMG_HEIGHT words of the frame store (307200 by default) one word
// per cycle, during which no item is accepted. A result waiting on the master
// stream does not block acceptance of the next item. The matrix registers may
// be written only while the block is idle.
module zbuffer_point_binner_unit #(
    parameter int IMG_WIDTH  = 640,
    parameter int IMG_HEIGHT = 480
) (
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream. tdata: pos_x[15:0], pos_y[31:16], pos_z[47:32],
    // pixel_index[66:48], zero fill above. tuser: func[1:0].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,
    // Master stream. tdata: out_x[15:0], out_y[31:16], out_z[47:32].
    // tuser: out_filled[0].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic [0:0]  m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // The matrix resets to the identity in Q4.12.
    localparam logic [63:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [63:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [63:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [63:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    logic [63:0]    mat_reg [4];
    logic [1:0]     reg_sel;
    logic           cfg_wr;
    zpb_pkg::cmd_t  cmd;
    zpb_pkg::stat_t stat;
    logic [47:0]    out_point;
    logic           out_filled;

    // Register i sits at byte address 8*i; the low address bits are ignored.
    assign reg_sel = paddr[4:3];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = mat_reg[reg_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= ROW0_RESET;
            mat_reg[1] <= ROW1_RESET;
            mat_reg[2] <= ROW2_RESET;
            mat_reg[3] <= ROW3_RESET;
        end
        else if (cfg_wr)
        begin
            mat_reg[reg_sel] <= pwdata;
        end
    end

    // The controller sequences each transaction; the datapath holds every
    // arithmetic unit and the frame store.
    zpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    zpb_dp #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .matrix      ({mat_reg[3], mat_reg[2], mat_reg[1], mat_reg[0]}),
        .pos_x       ($signed(s_tdata[15:0])),
        .pos_y       ($signed(s_tdata[31:16])),
        .pos_z       ($signed(s_tdata[47:32])),
        .pixel_index (s_tdata[66:48]),
        .out_point   (out_point),
        .out_filled  (out_filled),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    assign m_tdata    = out_point;
    assign m_tuser[0] = out_filled;

endmodule
